>>> hw/rtl/mmh3_pkg.sv
// Shared constants, command and status types for the MurmurHash3 x86_32 engine.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mmh3_pkg;

  localparam logic [31:0] MixC1    = 32'hCC9E2D51;
  localparam logic [31:0] MixC2    = 32'h1B873593;
  localparam logic [31:0] FoldAdd  = 32'hE6546B64;
  localparam logic [31:0] FinM1    = 32'h85EBCA6B;
  localparam logic [31:0] FinM2    = 32'hC2B2AE35;
  localparam logic [31:0] SeedRst  = 32'd7;
  localparam logic [2:0]  FullWord = 3'd4;

  // One-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture input transaction
    logic mix1;   // k = word * C1
    logic mix2;   // k = rotl(k, 15) * C2
    logic fold;   // fold k into the hash, xor length on the last word
    logic fin1;   // h = (h ^ h >> 16) * M1
    logic fin2;   // h = (h ^ h >> 13) * M2
    logic emit;   // h ^ h >> 16 into the output register, close the key
  } mmh3_cmd_t;

  typedef struct packed {
    logic is_last;   // captured word ends the key
    logic out_free;  // output register can take a result this cycle
  } mmh3_status_t;

endpackage

>>> hw/rtl/mmh3_ctrl.sv
// Sequencing state machine for the MurmurHash3 engine.
// Depends on mmh3_pkg for the command and status structs.
`timescale 1ns / 1ps

module mmh3_ctrl
  import mmh3_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mmh3_status_t status_i,
  output mmh3_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MIX1 = 7'b0000010,
    S_MIX2 = 7'b0000100,
    S_FOLD = 7'b0001000,
    S_FIN1 = 7'b0010000,
    S_FIN2 = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MIX1;
        end
      end
      S_MIX1: begin
        cmd_o.mix1 = 1'b1;
        state_d    = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.mix2 = 1'b1;
        state_d    = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = status_i.is_last ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        // hold until the previous result has been taken
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/mmh3_datapath.sv
// Datapath for the MurmurHash3 engine: seed, running hash, length, one shared
// 32x32 multiplier and the output register. Depends on mmh3_pkg.
`timescale 1ns / 1ps

module mmh3_datapath
  import mmh3_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic [31:0]  data_word_i,
  input  logic [2:0]   byte_count_i,
  input  logic         last_i,
  input  mmh3_cmd_t    cmd_i,
  output mmh3_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [31:0]  hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] hash_q, hash_d;
  logic [31:0] total_q;
  logic        mid_key_q;
  logic [31:0] word_q;
  logic [31:0] k_q;
  logic [2:0]  count_q;
  logic        last_q;
  logic        out_valid_q;
  logic [31:0] result_q;

  logic [2:0]  count_eff;
  logic [31:0] byte_mask;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] fold_x, fold_r, fold_v;
  logic [31:0] tail_h;

  // Clamp the byte count; a word that is not last is always full.
  always_comb begin
    if (!last_i || byte_count_i > FullWord) begin
      count_eff = FullWord;
    end else begin
      count_eff = byte_count_i;
    end
    case (count_eff)
      3'd0:    byte_mask = 32'h0000_0000;
      3'd1:    byte_mask = 32'h0000_00FF;
      3'd2:    byte_mask = 32'h0000_FFFF;
      3'd3:    byte_mask = 32'h00FF_FFFF;
      default: byte_mask = 32'hFFFF_FFFF;
    endcase
  end

  // Shared multiplier, low 32 bits of the product.
  always_comb begin
    if (cmd_i.mix2) begin
      mul_a = {k_q[16:0], k_q[31:17]};
      mul_b = MixC2;
    end else if (cmd_i.fin1) begin
      mul_a = hash_q ^ {16'd0, hash_q[31:16]};
      mul_b = FinM1;
    end else if (cmd_i.fin2) begin
      mul_a = hash_q ^ {13'd0, hash_q[31:13]};
      mul_b = FinM2;
    end else begin
      mul_a = word_q;
      mul_b = MixC1;
    end
  end

  assign mul_p = mul_a * mul_b;

  assign fold_x = hash_q ^ k_q;
  assign fold_r = {fold_x[18:0], fold_x[31:19]};
  assign fold_v = fold_r + {fold_r[29:0], 2'b00} + FoldAdd;

  always_comb begin
    if (count_q == FullWord) begin
      tail_h = fold_v;
    end else if (count_q != 3'd0) begin
      tail_h = hash_q ^ k_q;
    end else begin
      tail_h = hash_q;
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.load) begin
      hash_d = mid_key_q ? hash_q : seed_q;
    end else if (cmd_i.fold) begin
      hash_d = last_q ? (tail_h ^ total_q) : fold_v;
    end else if (cmd_i.fin1 || cmd_i.fin2) begin
      hash_d = mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedRst;
      hash_q      <= SeedRst;
      total_q     <= '0;
      mid_key_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      hash_q <= hash_d;
      if (cmd_i.load) begin
        last_q  <= last_i;
        total_q <= total_q + {29'd0, count_eff};
      end
      if (cmd_i.fold && !last_q) begin
        mid_key_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        mid_key_q <= 1'b0;
        total_q   <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q  <= data_word_i & byte_mask;
      count_q <= count_eff;
    end
    if (cmd_i.mix1 || cmd_i.mix2) begin
      k_q <= mul_p;
    end
    if (cmd_i.emit) begin
      result_q <= hash_q ^ {16'd0, hash_q[31:16]};
    end
  end

  assign status_o.is_last  = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = result_q;

endmodule

>>> hw/rtl/murmur3_32_hash.sv
// MurmurHash3 x86_32 engine, one 32-bit key word per input transaction.
// A word that is not last passes the mix1, mix2 and fold states before ready
// returns; a last word then passes fin1, fin2 and emit, which waits for a free
// output register, before its hash is registered. No new word is taken until
// the last one is through, as the single shared multiplier is used in sequence.
// Reset (async, active low) loads the seed with 7, clears the length and the
// key-in-progress flag, and empties the output register.
`timescale 1ns / 1ps

module murmur3_32_hash
  import mmh3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_value_o
);

  mmh3_cmd_t    cmd;
  mmh3_status_t status;

  mmh3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mmh3_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule
